// File: design/gtt_pkg.sv
// Package for the gated target tracker: field widths, codes and word types.
// No dependencies; imported by the top level, gtt_metric and gtt_track.

package gtt_pkg;

   // Request modes
   localparam logic [1:0] MODE_DETECT = 2'd0;
   localparam logic [1:0] MODE_EMPTY  = 2'd1;
   localparam logic [1:0] MODE_RESET  = 2'd2;
   localparam logic [1:0] MODE_IGNORE = 2'd3;

   // Register indexes of the csr port
   localparam logic CSR_GATE    = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   // Register reset values: 1.25 m gate, 3.0 s reacquire window
   localparam logic [15:0] GATE_RESET    = 16'd1250;
   localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

   // Candidate metric is 34 bits wide, all ones when no candidate yet
   localparam int          METRIC_W    = 34;
   localparam logic [33:0] METRIC_ONES = {METRIC_W{1'b1}};

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_NEW     = 3'd1,
      EV_REACQ   = 3'd2,
      EV_LOST    = 3'd3,
      EV_TIMEOUT = 3'd4
   } event_type;

   // One request word as held in the input register
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        range_mm;
      logic               last_in_frame;
      logic [31:0]        now_ms;
   } req_item_type;

   // One response word as held in the output register
   typedef struct packed {
      logic               target_valid;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic               tracking;
      logic               reacquiring;
      event_type          event_res;
   } rsp_item_type;

   // Decision stage output towards the output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_load_type;

endpackage

// File: design/gtt_if.sv
// Valid/ready channel interfaces for the tracker's request and response words.
// Depends on nothing; the package field widths are mirrored here.

interface gtt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]        range_mm;
   logic               last_in_frame;
   logic [31:0]        now_ms;

   modport source (output valid, mode, pos_x, pos_y, range_mm, last_in_frame, now_ms,
                   input ready);
   modport sink   (input valid, mode, pos_x, pos_y, range_mm, last_in_frame, now_ms,
                   output ready);
endinterface

interface gtt_rsp_if;
   logic               valid;
   logic               ready;
   logic               target_valid;
   logic signed [15:0] target_x;
   logic signed [15:0] target_y;
   logic               tracking;
   logic               reacquiring;
   logic [2:0]         event_res;

   modport source (output valid, target_valid, target_x, target_y, tracking, reacquiring,
                   event_res, input ready);
   modport sink   (input valid, target_valid, target_x, target_y, tracking, reacquiring,
                   event_res, output ready);
endinterface

// File: design/gated_target_tracker_top.sv
// Top level of the gated target tracker: channels, csr registers, word registers.
// Depends on gtt_pkg, gtt_if (gtt_req_if, gtt_rsp_if) and gtt_track.

// The tracker takes one request word per clock unless stalled. While a response
// waits at the output it takes one more word into its input register and then
// holds off. A word passes an input register, then the decision logic (a 16x16
// square of each coordinate difference, their sum and the running-minimum and
// gate compares), then the output register; a word waits in the input register
// while the output register is full and not being taken. Only the
// closing word of a frame (last detection or empty frame) gives a response;
// reset and ignored words give none. Throughput is one word per cycle; the
// input stalls only while the output register is full and not being taken.
// csr writes take effect from the next cycle and should be made while idle.

module gated_target_tracker_top
   import gtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gtt_req_if.sink     req_chan,
   gtt_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]  gate_ff;
   logic [15:0]  timeout_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         fire;
   rsp_load_type load;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff    <= GATE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GATE:    gate_ff    <= csr_wdata;
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            default:     gate_ff    <= gate_ff;
         endcase
      end
   end

   // Decision fires when the output slot is free or being emptied
   assign fire           = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.mode          <= req_chan.mode;
         in_item_ff.pos_x         <= req_chan.pos_x;
         in_item_ff.pos_y         <= req_chan.pos_y;
         in_item_ff.range_mm      <= req_chan.range_mm;
         in_item_ff.last_in_frame <= req_chan.last_in_frame;
         in_item_ff.now_ms        <= req_chan.now_ms;
      end
   end

   gtt_track u_track (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .gate_mm    (gate_ff),
      .timeout_ms (timeout_ff),
      .load       (load)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         rsp_item_ff <= load.item;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.target_valid = rsp_item_ff.target_valid;
   assign rsp_chan.target_x     = rsp_item_ff.target_x;
   assign rsp_chan.target_y     = rsp_item_ff.target_y;
   assign rsp_chan.tracking     = rsp_item_ff.tracking;
   assign rsp_chan.reacquiring  = rsp_item_ff.reacquiring;
   assign rsp_chan.event_res    = rsp_item_ff.event_res;

`ifndef SYNTHESIS
   // A new response only follows a decision cycle
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("response appeared without a decision");

   // Tracking and reacquiring are never reported together
   a_state_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.tracking && rsp_chan.reacquiring))
      else $error("tracking and reacquiring both set");

   // After a timeout a track is held exactly when a new target was picked
   a_timeout_pick: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.event_res == EV_TIMEOUT))
         |-> (rsp_chan.tracking == rsp_chan.target_valid))
      else $error("timeout word inconsistent with selection");

   // A stalled response word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !load.valid)
      else $error("response overwritten while stalled");
`endif

endmodule

// File: design/gtt_metric.sv
// Squared distance between a detection and the last target position.
// Depends on gtt_pkg; purely combinational, two 16x16 squares and one add.

module gtt_metric
   import gtt_pkg::*;
(
   input  logic signed [15:0] pos_x,
   input  logic signed [15:0] pos_y,
   input  logic signed [15:0] last_x,
   input  logic signed [15:0] last_y,
   output logic [32:0]        sq_dist
);

   logic [16:0] dx, dy, ndx, ndy;
   logic [15:0] mag_x, mag_y;
   logic [31:0] sq_x, sq_y;

   // 17-bit differences, magnitude always fits in 16 bits
   assign dx  = {pos_x[15], pos_x} - {last_x[15], last_x};
   assign dy  = {pos_y[15], pos_y} - {last_y[15], last_y};
   assign ndx = 17'd0 - dx;
   assign ndy = 17'd0 - dy;
   assign mag_x = dx[16] ? ndx[15:0] : dx[15:0];
   assign mag_y = dy[16] ? ndy[15:0] : dy[15:0];

   assign sq_x    = {16'd0, mag_x} * {16'd0, mag_x};
   assign sq_y    = {16'd0, mag_y} * {16'd0, mag_y};
   assign sq_dist = {1'b0, sq_x} + {1'b0, sq_y};

endmodule

// File: design/gtt_track.sv
// Track state and per-word decision: frame start, candidate update, frame end.
// Depends on gtt_pkg and gtt_metric.

module gtt_track
   import gtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  logic [15:0]  gate_mm,
   input  logic [15:0]  timeout_ms,
   output rsp_load_type load
);

   logic               has_track_ff, has_track_in;
   logic               in_reacq_ff, in_reacq_in;
   logic signed [15:0] last_x_ff, last_x_in;
   logic signed [15:0] last_y_ff, last_y_in;
   logic [31:0]        lost_time_ff, lost_time_in;
   logic               mid_frame_ff, mid_frame_in;
   logic               assoc_ff, assoc_in;
   logic               timed_out_ff, timed_out_in;
   logic               cand_found_ff, cand_found_in;
   logic [33:0]        cand_metric_ff, cand_metric_in;
   logic signed [15:0] cand_x_ff, cand_x_in;
   logic signed [15:0] cand_y_ff, cand_y_in;

   logic [32:0]        sq_dist;
   logic [31:0]        elapsed;
   logic [31:0]        gate_sq;
   logic               is_detect, is_empty, start, expired, frame_end, hit;
   logic               s_has, s_reacq, s_assoc, s_timed;
   logic               c_found;
   logic [33:0]        c_metric, metric;
   logic signed [15:0] c_x, c_y;
   logic               n_found;
   logic [33:0]        n_metric;
   logic signed [15:0] n_x, n_y;
   event_type          ev;
   logic               res_valid_tgt;

   gtt_metric u_metric (
      .pos_x   (item.pos_x),
      .pos_y   (item.pos_y),
      .last_x  (last_x_ff),
      .last_y  (last_y_ff),
      .sq_dist (sq_dist)
   );

   assign elapsed = item.now_ms - lost_time_ff;
   assign gate_sq = {16'd0, gate_mm} * {16'd0, gate_mm};

   // Frame start view: timeout check, association latch, candidate cleared
   always_comb begin
      is_detect = (item.mode == MODE_DETECT);
      is_empty  = (item.mode == MODE_EMPTY);
      start     = !mid_frame_ff;
      expired   = in_reacq_ff && (elapsed > {16'd0, timeout_ms});
      s_has     = (start && expired) ? 1'b0 : has_track_ff;
      s_reacq   = (start && expired) ? 1'b0 : in_reacq_ff;
      s_timed   = start ? expired : timed_out_ff;
      s_assoc   = start ? (s_has || s_reacq) : assoc_ff;
      c_found   = start ? 1'b0 : cand_found_ff;
      c_metric  = start ? METRIC_ONES : cand_metric_ff;
      c_x       = start ? 16'sd0 : cand_x_ff;
      c_y       = start ? 16'sd0 : cand_y_ff;
   end

   // Running minimum; ties keep the earlier detection
   always_comb begin
      metric   = s_assoc ? {1'b0, sq_dist} : {18'd0, item.range_mm};
      n_found  = c_found;
      n_metric = c_metric;
      n_x      = c_x;
      n_y      = c_y;
      if (is_detect && (metric < c_metric)) begin
         n_found  = 1'b1;
         n_metric = metric;
         n_x      = item.pos_x;
         n_y      = item.pos_y;
      end
   end

   assign frame_end = is_empty || (is_detect && item.last_in_frame);
   assign hit       = n_found && (n_metric < {2'd0, gate_sq});

   // Next state
   always_comb begin
      has_track_in   = has_track_ff;
      in_reacq_in    = in_reacq_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      lost_time_in   = lost_time_ff;
      mid_frame_in   = mid_frame_ff;
      assoc_in       = assoc_ff;
      timed_out_in   = timed_out_ff;
      cand_found_in  = cand_found_ff;
      cand_metric_in = cand_metric_ff;
      cand_x_in      = cand_x_ff;
      cand_y_in      = cand_y_ff;
      ev             = EV_NONE;
      res_valid_tgt  = 1'b0;

      if (item.mode == MODE_RESET) begin
         // last position is kept
         has_track_in   = 1'b0;
         in_reacq_in    = 1'b0;
         mid_frame_in   = 1'b0;
         assoc_in       = 1'b0;
         timed_out_in   = 1'b0;
         cand_found_in  = 1'b0;
         cand_metric_in = METRIC_ONES;
         cand_x_in      = 16'sd0;
         cand_y_in      = 16'sd0;
      end else if (is_detect || is_empty) begin
         has_track_in = s_has;
         in_reacq_in  = s_reacq;
         if (frame_end) begin
            if (s_assoc) begin
               if (hit) begin
                  res_valid_tgt = 1'b1;
                  ev            = s_reacq ? EV_REACQ : EV_NONE;
                  has_track_in  = 1'b1;
                  in_reacq_in   = 1'b0;
               end else begin
                  if (s_has) begin
                     lost_time_in = item.now_ms;
                     in_reacq_in  = 1'b1;
                     ev           = EV_LOST;
                  end
                  has_track_in = 1'b0;
               end
            end else begin
               if (n_found) begin
                  res_valid_tgt = 1'b1;
                  has_track_in  = 1'b1;
                  ev            = EV_NEW;
               end
               if (s_timed) begin
                  ev = EV_TIMEOUT;
               end
            end
            if (res_valid_tgt) begin
               last_x_in = n_x;
               last_y_in = n_y;
            end
            mid_frame_in   = 1'b0;
            assoc_in       = 1'b0;
            timed_out_in   = 1'b0;
            cand_found_in  = 1'b0;
            cand_metric_in = METRIC_ONES;
            cand_x_in      = 16'sd0;
            cand_y_in      = 16'sd0;
         end else begin
            mid_frame_in   = 1'b1;
            assoc_in       = s_assoc;
            timed_out_in   = s_timed;
            cand_found_in  = n_found;
            cand_metric_in = n_metric;
            cand_x_in      = n_x;
            cand_y_in      = n_y;
         end
      end
   end

   // Response word for the output register
   always_comb begin
      load.valid             = fire && frame_end;
      load.item.target_valid = res_valid_tgt;
      load.item.target_x     = last_x_in;
      load.item.target_y     = last_y_in;
      load.item.tracking     = has_track_in;
      load.item.reacquiring  = in_reacq_in;
      load.item.event_res    = ev;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         has_track_ff   <= 1'b0;
         in_reacq_ff    <= 1'b0;
         last_x_ff      <= 16'sd0;
         last_y_ff      <= 16'sd0;
         lost_time_ff   <= 32'd0;
         mid_frame_ff   <= 1'b0;
         assoc_ff       <= 1'b0;
         timed_out_ff   <= 1'b0;
         cand_found_ff  <= 1'b0;
         cand_metric_ff <= METRIC_ONES;
         cand_x_ff      <= 16'sd0;
         cand_y_ff      <= 16'sd0;
      end else if (fire) begin
         has_track_ff   <= has_track_in;
         in_reacq_ff    <= in_reacq_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         lost_time_ff   <= lost_time_in;
         mid_frame_ff   <= mid_frame_in;
         assoc_ff       <= assoc_in;
         timed_out_ff   <= timed_out_in;
         cand_found_ff  <= cand_found_in;
         cand_metric_ff <= cand_metric_in;
         cand_x_ff      <= cand_x_in;
         cand_y_ff      <= cand_y_in;
      end
   end

endmodule

// File: bench/gated_target_tracker_top_test.sv
// Testbench for gated_target_tracker_top: frames of detections with a local tracker predictor.
// Depends on gtt_pkg, gtt_if (gtt_req_if, gtt_rsp_if) and the design top level.

module gated_target_tracker_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gtt_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_WORDS    = 100;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   gtt_req_if req_chan();
   gtt_rsp_if rsp_chan();

   gated_target_tracker_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Tracker state as predicted, plus the register copies
   logic [15:0]        cfg_gate;
   logic [15:0]        cfg_timeout;
   logic               trk_held;
   logic               trk_reacq;
   logic signed [15:0] trk_x;
   logic signed [15:0] trk_y;
   logic [31:0]        trk_lost_ms;
   logic               frame_open;
   logic               frame_gated;
   logic               frame_expired;
   logic               best_found;
   logic [33:0]        best_metric;
   logic signed [15:0] best_x;
   logic signed [15:0] best_y;

   req_item_type pending_words[$];
   rsp_item_type expected_decisions[$];
   rsp_item_type want;

   int              mismatch_count = 0;
   int              words_queued   = 0;
   int              burst_left     = 1;
   int              gap_left       = 0;
   int              style_left     = 0;
   int              style_cycle    = 0;
   int              quiet_cycles   = 0;
   stall_style_type stall_style    = STALL_NONE;

   task automatic clear_best();
      best_found  = 1'b0;
      best_metric = METRIC_ONES;
      best_x      = '0;
      best_y      = '0;
   endtask

   // Advance the predicted tracker by one accepted word; frame ends queue a decision
   task automatic predict_word(input req_item_type w);
      logic [31:0]  elapsed;
      logic [33:0]  metric;
      logic [33:0]  gate_sq;
      logic [16:0]  ax;
      logic [16:0]  ay;
      int           dx;
      int           dy;
      logic         won;
      event_type    ev;
      rsp_item_type d;
      if (w.mode == MODE_IGNORE) return;
      if (w.mode == MODE_RESET) begin
         trk_held      = 1'b0;
         trk_reacq     = 1'b0;
         frame_open    = 1'b0;
         frame_gated   = 1'b0;
         frame_expired = 1'b0;
         clear_best();
         return;
      end
      // first word of a frame: expire the window, latch association
      if (!frame_open) begin
         elapsed       = w.now_ms - trk_lost_ms;
         frame_expired = 1'b0;
         if (trk_reacq && elapsed > 32'(cfg_timeout)) begin
            trk_reacq     = 1'b0;
            trk_held      = 1'b0;
            frame_expired = 1'b1;
         end
         frame_gated = trk_held || trk_reacq;
         clear_best();
         frame_open = 1'b1;
      end
      // running minimum; strict compare keeps the earlier of equals
      if (w.mode == MODE_DETECT) begin
         if (frame_gated) begin
            dx     = int'(w.pos_x) - int'(trk_x);
            dy     = int'(w.pos_y) - int'(trk_y);
            ax     = 17'((dx < 0) ? -dx : dx);
            ay     = 17'((dy < 0) ? -dy : dy);
            metric = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
         end else begin
            metric = 34'(w.range_mm);
         end
         if (metric < best_metric) begin
            best_metric = metric;
            best_x      = w.pos_x;
            best_y      = w.pos_y;
            best_found  = 1'b1;
         end
      end
      if (w.mode == MODE_EMPTY || w.last_in_frame) begin
         gate_sq = 34'(cfg_gate) * 34'(cfg_gate);
         won     = 1'b0;
         ev      = EV_NONE;
         if (frame_gated) begin
            if (best_found && best_metric < gate_sq) begin
               won       = 1'b1;
               ev        = trk_reacq ? EV_REACQ : EV_NONE;
               trk_held  = 1'b1;
               trk_reacq = 1'b0;
            end else begin
               // only a held track is lost; a miss while reacquiring is quiet
               if (trk_held) begin
                  trk_lost_ms = w.now_ms;
                  trk_reacq   = 1'b1;
                  ev          = EV_LOST;
               end
               trk_held = 1'b0;
            end
         end else begin
            if (best_found) begin
               won      = 1'b1;
               trk_held = 1'b1;
               ev       = EV_NEW;
            end
            if (frame_expired) ev = EV_TIMEOUT;
         end
         if (won) begin
            trk_x = best_x;
            trk_y = best_y;
         end
         d.target_valid = won;
         d.target_x     = trk_x;
         d.target_y     = trk_y;
         d.tracking     = trk_held;
         d.reacquiring  = trk_reacq;
         d.event_res    = ev;
         expected_decisions = {expected_decisions, d};
         frame_open    = 1'b0;
         frame_expired = 1'b0;
         frame_gated   = 1'b0;
         clear_best();
      end
   endtask

   task automatic add_word(input logic [1:0] mode, input int x, input int y, input int rng_mm,
                           input logic last, input logic [31:0] now);
      req_item_type w;
      w.mode          = mode;
      w.pos_x         = 16'(x);
      w.pos_y         = 16'(y);
      w.range_mm      = 16'(rng_mm);
      w.last_in_frame = last;
      w.now_ms        = now;
      pending_words = {pending_words, w};
      if (mode != MODE_IGNORE) words_queued++;
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GATE) cfg_gate = value;
      else cfg_timeout = value;
   endtask

   // Wait for every word taken and every decision seen, then let the pipe empty
   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Request driver: bursts of words with random gaps, holds a word until taken
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!(req_chan.valid && !req_chan.ready)) begin
         if (req_chan.valid) predict_word(pending_words.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_chan.valid         <= 1'b1;
            req_chan.mode          <= pending_words[0].mode;
            req_chan.pos_x         <= pending_words[0].pos_x;
            req_chan.pos_y         <= pending_words[0].pos_y;
            req_chan.range_mm      <= pending_words[0].range_mm;
            req_chan.last_in_frame <= pending_words[0].last_in_frame;
            req_chan.now_ms        <= pending_words[0].now_ms;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response monitor: check against the oldest expected decision, then set ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_decisions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected decision: valid=%0b x=%0d y=%0d trk=%0b reacq=%0b ev=%0d",
                           rsp_chan.target_valid, rsp_chan.target_x, rsp_chan.target_y,
                           rsp_chan.tracking, rsp_chan.reacquiring, rsp_chan.event_res);
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_chan.target_valid !== want.target_valid ||
                   rsp_chan.target_x !== want.target_x ||
                   rsp_chan.target_y !== want.target_y ||
                   rsp_chan.tracking !== want.tracking ||
                   rsp_chan.reacquiring !== want.reacquiring ||
                   rsp_chan.event_res !== want.event_res) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("decision mismatch at %0t", $realtime);
                     $display("  expected valid=%0b x=%0d y=%0d trk=%0b reacq=%0b ev=%0d",
                              want.target_valid, want.target_x, want.target_y,
                              want.tracking, want.reacquiring, want.event_res);
                     $display("  got      valid=%0b x=%0d y=%0d trk=%0b reacq=%0b ev=%0d",
                              rsp_chan.target_valid, rsp_chan.target_x, rsp_chan.target_y,
                              rsp_chan.tracking, rsp_chan.reacquiring, rsp_chan.event_res);
                  end
               end
            end
         end
         // stall pattern picks a new random style when its run is spent
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 300);
            style_cycle = 0;
         end else begin
            style_left--;
         end
         style_cycle++;
         case (stall_style)
            STALL_NONE:  rsp_chan.ready <= 1'b1;
            STALL_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_chan.ready <= ((style_cycle % 9) < 3);
         endcase
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] now_v;
      logic [15:0] gate_v;
      logic [15:0] timeout_v;
      int          spread;
      int          walk_x;
      int          walk_y;
      int          n;
      int          spot;
      int          kind;
      int          roll;
      int          target;
      int          x;
      int          y;
      int          r;
      int          prev_x;
      int          prev_y;
      int          prev_r;
      logic        by_empty;

      // everything known from time zero
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_GATE;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.mode          = MODE_IGNORE;
      req_chan.pos_x         = '0;
      req_chan.pos_y         = '0;
      req_chan.range_mm      = '0;
      req_chan.last_in_frame = 1'b0;
      req_chan.now_ms        = '0;
      rsp_chan.ready         = 1'b0;
      cfg_gate               = GATE_RESET;
      cfg_timeout            = TIMEOUT_RESET;
      trk_held               = 1'b0;
      trk_reacq              = 1'b0;
      trk_x                  = '0;
      trk_y                  = '0;
      trk_lost_ms            = '0;
      frame_open             = 1'b0;
      frame_gated            = 1'b0;
      frame_expired          = 1'b0;
      clear_best();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset gate and window
      add_word(MODE_EMPTY, 0, 0, 0, 1'b0, 100);                    // empty, no track
      add_word(MODE_DETECT, 1000, 2000, 5000, 1'b0, 200);
      add_word(MODE_DETECT, -500, 300, 800, 1'b0, 200);
      add_word(MODE_DETECT, 32767, -32768, 800, 1'b1, 200);        // range tie, earlier wins
      add_word(MODE_DETECT, -500, 1550, 65535, 1'b1, 300);         // on the gate edge: lost
      add_word(MODE_DETECT, -500, 1549, 0, 1'b1, 400);             // just inside: reacquired
      add_word(MODE_EMPTY, -1, -1, 65535, 1'b1, 500);              // lost again
      add_word(MODE_EMPTY, 0, 0, 0, 1'b0, 3500);                   // window exactly full
      add_word(MODE_DETECT, -32768, -32768, 0, 1'b0, 3501);        // window expired
      add_word(MODE_DETECT, 32767, 32767, 65535, 1'b1, 3501);
      add_word(MODE_DETECT, -32668, -32768, 100, 1'b1, 3600);      // continued track
      add_word(MODE_DETECT, -32568, -32768, 7, 1'b0, 3700);
      add_word(MODE_EMPTY, 12345, -12345, 4321, 1'b0, 3700);       // empty closes open frame
      add_word(MODE_DETECT, 0, 0, 1, 1'b0, 3800);
      add_word(MODE_RESET, 1, 2, 3, 1'b1, 3800);                   // abandons the frame
      add_word(MODE_IGNORE, -1, -1, 65535, 1'b1, 32'hFFFF_FFFF);
      add_word(MODE_DETECT, 32767, 32767, 65535, 1'b1, 3900);      // new after reset
      add_word(MODE_DETECT, -32768, -32768, 0, 1'b1, 4000);        // farthest miss
      add_word(MODE_DETECT, 32767, -32768, 0, 1'b1, 4001);         // miss while reacquiring
      add_word(MODE_RESET, 0, 0, 0, 1'b0, 4001);
      wait_idle();

      // Random phases, each under its own gate and window
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       begin gate_v = 16'd0;     timeout_v = 16'd0;     end
            1:       begin gate_v = 16'hFFFF;  timeout_v = 16'hFFFF;  end
            2:       begin gate_v = GATE_RESET; timeout_v = TIMEOUT_RESET; end
            4:       begin gate_v = 16'd200;   timeout_v = 16'd1;     end
            6:       begin gate_v = 16'd5000;  timeout_v = 16'd100;   end
            7:       begin gate_v = GATE_RESET; timeout_v = TIMEOUT_RESET; end
            default: begin gate_v = 16'($urandom); timeout_v = 16'($urandom); end
         endcase
         write_csr(CSR_GATE, gate_v);
         write_csr(CSR_TIMEOUT, timeout_v);
         if (p == 2) now_v = 32'hFFFF_F000;        // frames wrap the timestamp
         else now_v = $urandom;
         spread = int'(cfg_gate) / 2 + 1;
         walk_x = int'($urandom_range(0, 20000)) - 10000;
         walk_y = int'($urandom_range(0, 20000)) - 10000;
         target = words_queued + PHASE_WORDS;
         while (words_queued < target) begin
            // frame time: mostly short steps, some on the window edge, some anywhere
            roll = $urandom_range(0, 99);
            if (roll < 80) now_v = now_v + $urandom_range(20, 200);
            else if (roll < 95) now_v = now_v + 32'(cfg_timeout) + $urandom_range(0, 2) - 1;
            else now_v = now_v + $urandom;
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
               if (kind < 2)
                  add_word(MODE_DETECT, int'($urandom), int'($urandom), int'($urandom),
                           1'b0, now_v);
               add_word(MODE_RESET, int'($urandom), int'($urandom), int'($urandom),
                        1'($urandom), now_v);
            end else if (kind < 15) begin
               add_word(MODE_EMPTY, int'($urandom), int'($urandom), int'($urandom),
                        1'($urandom), now_v);
            end else begin
               n        = $urandom_range(1, 5);
               spot     = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, n - 1);
               by_empty = ($urandom_range(0, 9) == 0);
               walk_x   = clamp16(walk_x + int'($urandom_range(0, spread)) - spread / 2);
               walk_y   = clamp16(walk_y + int'($urandom_range(0, spread)) - spread / 2);
               prev_x   = walk_x;
               prev_y   = walk_y;
               prev_r   = 0;
               for (int i = 0; i < n; i++) begin
                  roll = $urandom_range(0, 9);
                  if (i == spot) begin
                     // the walking person, close to the robot
                     x = clamp16(walk_x + int'($urandom_range(0, 2 * spread)) - spread);
                     y = clamp16(walk_y + int'($urandom_range(0, 2 * spread)) - spread);
                     r = $urandom_range(0, 3000);
                  end else if (roll < 3) begin
                     x = clamp16(walk_x + int'($urandom_range(0, 2 * spread)) - spread);
                     y = clamp16(walk_y + int'($urandom_range(0, 2 * spread)) - spread);
                     r = $urandom_range(0, 65535);
                  end else if (roll == 3 && i > 0) begin
                     // same as the one before: equal metric either way
                     x = prev_x;
                     y = prev_y;
                     r = prev_r;
                  end else begin
                     x = int'($urandom);
                     y = int'($urandom);
                     r = int'($urandom);
                  end
                  if ($urandom_range(0, 14) == 0)
                     add_word(MODE_IGNORE, int'($urandom), int'($urandom), int'($urandom),
                              1'($urandom), $urandom);
                  add_word(MODE_DETECT, x, y, r, (i == n - 1) && !by_empty, now_v);
                  prev_x = x;
                  prev_y = y;
                  prev_r = r;
               end
               if (by_empty)
                  add_word(MODE_EMPTY, int'($urandom), int'($urandom), int'($urandom),
                           1'($urandom), now_v);
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0 && expected_decisions.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
